/* rtl/pct_pkg.sv */
// Package for the pileup consensus table: request codes, register indexes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package pct_pkg;

    // Default sizes of the column store
    localparam int DEF_COLUMNS     = 1024;
    localparam int DEF_COUNT_BITS  = 16;
    localparam int DEF_WEIGHT_BITS = 32;

    // Quotient bits of the support divide (integer bit plus 16 fraction bits)
    localparam int Q_BITS = 17;

    // Request codes
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_QUERY  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_USE_QUALITY   = 2'd0;
    localparam logic [1:0] CFG_SUBJECT_BEGIN = 2'd1;
    localparam logic [1:0] CFG_SUBJECT_END   = 2'd2;
    localparam logic [1:0] CFG_COLUMN_COUNT  = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE,
        S_EVAL,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic upd_we;
        logic clr_we;
        logic eval;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

/* rtl/pct_controller.sv */
// Controller state machine of the pileup consensus table.
// Depends on pct_pkg for states, request codes and the command/status structs.
module pct_controller
    import pct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic [1:0] i_req_type,
    input  t_sts       i_sts,
    output logic       o_s_tready,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register; reset starts with a clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
                if (i_s_tvalid) begin
                    unique case (i_req_type) inside
                        REQ_CLEAR:              n_state = S_CLEAR;
                        REQ_ADD, REQ_REMOVE:    n_state = S_UPDATE;
                        default:                n_state = S_EVAL;
                    endcase
                end
            end
            S_UPDATE: begin
                o_cmd.upd_we = 1'b1;
                n_state      = S_IDLE;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/pct_datapath.sv */
// Datapath of the pileup consensus table: column store, update, consensus,
// serial support divider and output register. Depends on pct_pkg.
module pct_datapath
    import pct_pkg::*;
#(
    parameter int COLUMNS     = DEF_COLUMNS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data,
    input  logic [1:0]  i_req_type,
    input  logic [10:0] i_shift,
    input  logic [9:0]  i_position,
    input  logic [1:0]  i_base,
    input  logic [15:0] i_quality_weight,
    input  logic [15:0] i_weight_factor,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [9:0]  o_column,
    output logic [1:0]  o_consensus_base,
    output logic [16:0] o_support,
    output logic [15:0] o_coverage,
    output logic [31:0] o_consensus_weight,
    output logic [33:0] o_column_weight,
    output logic [31:0] o_orig_weight,
    output logic [15:0] o_orig_count,
    output logic        o_in_subject
);

    localparam int AW    = $clog2(COLUMNS);
    localparam int CB    = COUNT_BITS;
    localparam int WB    = WEIGHT_BITS;
    localparam int CNT0  = 4 * WB;
    localparam int COV0  = 4 * WB + 4 * CB;
    localparam int ROW_W = 4 * WB + 5 * CB;

    // Configuration registers
    logic        r_use_quality;
    logic [9:0]  r_sub_begin;
    logic [10:0] r_sub_end;
    logic [10:0] r_col_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_quality <= 1'b1;
            r_sub_begin   <= '0;
            r_sub_end     <= '0;
            r_col_count   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_USE_QUALITY:   r_use_quality <= i_cfg_data[0];
                CFG_SUBJECT_BEGIN: r_sub_begin   <= i_cfg_data[9:0];
                CFG_SUBJECT_END:   r_sub_end     <= i_cfg_data;
                CFG_COLUMN_COUNT:  r_col_count   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Column address and range checks on the incoming word
    logic [12:0]   col;
    logic          add_hit;
    logic          qry_hit;
    logic [AW-1:0] rd_addr;
    logic [31:0]   prod;
    logic [16:0]   w_in;

    assign col     = {3'b000, r_sub_begin} + {{2{i_shift[10]}}, i_shift}
                   + {3'b000, i_position};
    assign add_hit = !col[12] && (col[11:0] < {1'b0, r_col_count})
                   && (32'(col[11:0]) < COLUMNS);
    assign qry_hit = ({1'b0, i_position} < r_col_count) && (32'(i_position) < COLUMNS);
    assign rd_addr = (i_req_type == REQ_QUERY) ? AW'(i_position) : AW'(col[11:0]);
    assign prod    = i_weight_factor * i_quality_weight;
    assign w_in    = r_use_quality ? prod[31:15] : {1'b0, i_weight_factor};

    // Capture the request word
    logic [AW-1:0] r_addr;
    logic          r_hit;
    logic          r_remove;
    logic [16:0]   r_w;
    logic [1:0]    r_base;
    logic [9:0]    r_pos;
    logic          r_insub;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_addr   <= rd_addr;
            r_hit    <= (i_req_type == REQ_QUERY) ? qry_hit : add_hit;
            r_remove <= (i_req_type == REQ_REMOVE);
            r_w      <= w_in;
            r_base   <= i_base;
            r_pos    <= i_position;
            r_insub  <= (i_position >= r_sub_begin) && ({1'b0, i_position} < r_sub_end);
        end
    end

    // Clearing sweep counter
    logic [AW-1:0] r_clr;
    logic          clr_done;

    assign clr_done = (r_clr == AW'(COLUMNS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_we) begin
            r_clr <= clr_done ? '0 : r_clr + 1'b1;
        end
    end

    // Read-modify-write of one row
    logic [ROW_W-1:0] r_rdata;
    logic [ROW_W-1:0] n_row;
    logic [WB-1:0]    w_old;
    logic [WB:0]      w_sum;
    logic [CB-1:0]    c_old;
    logic [CB-1:0]    v_old;

    always_comb begin
        n_row = r_rdata;
        w_old = r_rdata[32'(r_base) * WB +: WB];
        c_old = r_rdata[CNT0 + 32'(r_base) * CB +: CB];
        v_old = r_rdata[COV0 +: CB];
        w_sum = {1'b0, w_old} + (WB + 1)'(r_w);
        if (r_remove) begin
            n_row[32'(r_base) * WB +: WB] = (w_old > WB'(r_w)) ? w_old - WB'(r_w) : '0;
            n_row[CNT0 + 32'(r_base) * CB +: CB] = (c_old == '0) ? '0 : c_old - 1'b1;
            n_row[COV0 +: CB] = (v_old == '0) ? '0 : v_old - 1'b1;
        end else begin
            n_row[32'(r_base) * WB +: WB] = w_sum[WB] ? '1 : w_sum[WB-1:0];
            n_row[CNT0 + 32'(r_base) * CB +: CB] = (&c_old) ? c_old : c_old + 1'b1;
            n_row[COV0 +: CB] = (&v_old) ? v_old : v_old + 1'b1;
        end
    end

    // Column store: one write port, one registered read port
    logic [ROW_W-1:0] r_mem [COLUMNS];
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [ROW_W-1:0] mem_wdata;

    assign mem_we    = i_cmd.clr_we || (i_cmd.upd_we && r_hit);
    assign mem_waddr = i_cmd.clr_we ? r_clr : r_addr;
    assign mem_wdata = i_cmd.clr_we ? '0 : n_row;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (i_cmd.accept) r_rdata <= r_mem[rd_addr];
    end

    // Consensus, column weight and subject base lookup
    logic [ROW_W-1:0] row_v;
    logic [WB-1:0]    wt [4];
    logic [WB-1:0]    cons_w;
    logic [1:0]       cons_b;
    logic [WB+1:0]    col_w;

    always_comb begin
        row_v = r_hit ? r_rdata : '0;
        for (int k = 0; k < 4; k++) begin
            wt[k] = row_v[k * WB +: WB];
        end
        cons_w = wt[0];
        cons_b = 2'd0;
        for (int k = 1; k < 4; k++) begin
            if (wt[k] > cons_w) begin
                cons_w = wt[k];
                cons_b = 2'(k);
            end
        end
        col_w = (WB + 2)'(wt[0]) + (WB + 2)'(wt[1]) + (WB + 2)'(wt[2]) + (WB + 2)'(wt[3]);
    end

    logic [1:0]    r_cons_b;
    logic [WB-1:0] r_cons_w;
    logic [CB-1:0] r_cov;
    logic [WB-1:0] r_orig_w;
    logic [CB-1:0] r_orig_c;

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_cons_b <= cons_b;
            r_cons_w <= cons_w;
            r_cov    <= row_v[COV0 +: CB];
            r_orig_w <= r_insub ? row_v[32'(r_base) * WB +: WB] : '0;
            r_orig_c <= r_insub ? row_v[CNT0 + 32'(r_base) * CB +: CB] : '0;
        end
    end

    // Restoring divider, one quotient bit a cycle
    logic [WB+2:0]       r_rem;
    logic [WB+1:0]       r_den;
    logic [Q_BITS-1:0]   r_q;
    logic [4:0]          r_k;
    logic [WB+2:0]       rem_sh;
    logic                rem_ge;

    assign rem_sh = (r_k == '0) ? r_rem : {r_rem[WB+1:0], 1'b0};
    assign rem_ge = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_rem <= (WB + 3)'(cons_w);
            r_den <= col_w;
            r_q   <= '0;
            r_k   <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_sh - {1'b0, r_den} : rem_sh;
            r_q   <= {r_q[Q_BITS-2:0], rem_ge};
            r_k   <= r_k + 1'b1;
        end
    end

    // Output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_column           <= r_pos;
            o_consensus_base   <= r_cons_b;
            o_support          <= (r_den == '0) ? '0 : r_q;
            o_coverage         <= 16'(r_cov);
            o_consensus_weight <= 32'(r_cons_w);
            o_column_weight    <= 34'(r_den);
            o_orig_weight      <= 32'(r_orig_w);
            o_orig_count       <= 16'(r_orig_c);
            o_in_subject       <= r_insub;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sts.clr_done = clr_done;
    assign o_sts.div_done = (r_k == 5'(Q_BITS - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

/* rtl/pileup_consensus_table_unit.sv */
// Pileup consensus table: per-column base counts and weights with query.
// Top level; instantiates pct_controller and pct_datapath, uses pct_pkg.
//
// Use:
//   Slave stream carries requests: tuser is the request kind (clear, add,
//   remove, query), tdata the read offset, position, base and weights,
//   tlast marks the last base of a read. Master stream carries one word
//   per query. Configuration is a plain write port, written while idle.
// Sequence:
//   An add or remove is accepted with its row read, then written back.
//   A query reads its row, forms the consensus and column sum, runs a
//   restoring divider that gives one quotient bit per cycle, and loads the
//   output register once it is free. A clear sweeps the store one row a
//   cycle; no word is accepted during the sweep.
// Reset:
//   Synchronous reset starts the same clearing sweep and sets use_quality
//   to 1, the other configuration registers to 0.
// Stall:
//   A finished result waits in the output register; new requests are still
//   accepted. A second query result holds in the datapath, and no request is accepted, until the first is taken.
module pileup_consensus_table_unit
    import pct_pkg::*;
#(
    parameter int COLUMNS     = DEF_COLUMNS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [10:0]  i_cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // shift[10:0], position[20:11], base[22:21], quality_weight[38:23],
    // weight_factor[54:39], zero[55]
    input  logic [55:0]  s_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // column[9:0], consensus_base[11:10], support[28:12], coverage[44:29],
    // consensus_weight[76:45], column_weight[110:77], orig_weight[142:111],
    // orig_count[158:143], zero[159]
    output logic [159:0] m_tdata,
    // in_subject[0]
    output logic         m_tuser
);

    t_cmd cmd;
    t_sts sts;

    pct_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_req_type (s_tuser),
        .i_sts      (sts),
        .o_s_tready (s_tready),
        .o_cmd      (cmd)
    );

    pct_datapath #(
        .COLUMNS     (COLUMNS),
        .COUNT_BITS  (COUNT_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_req_type         (s_tuser),
        .i_shift            (s_tdata[10:0]),
        .i_position         (s_tdata[20:11]),
        .i_base             (s_tdata[22:21]),
        .i_quality_weight   (s_tdata[38:23]),
        .i_weight_factor    (s_tdata[54:39]),
        .i_out_ready        (m_tready),
        .o_out_valid        (m_tvalid),
        .o_column           (m_tdata[9:0]),
        .o_consensus_base   (m_tdata[11:10]),
        .o_support          (m_tdata[28:12]),
        .o_coverage         (m_tdata[44:29]),
        .o_consensus_weight (m_tdata[76:45]),
        .o_column_weight    (m_tdata[110:77]),
        .o_orig_weight      (m_tdata[142:111]),
        .o_orig_count       (m_tdata[158:143]),
        .o_in_subject       (m_tuser)
    );

    assign m_tdata[159] = 1'b0;

    // A loaded result is presented on the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> m_tvalid)
        else $error("result load not shown on master side");

    // Sweep and update never share the write port
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.upd_we && cmd.clr_we))
        else $error("clear sweep and update write together");

    // Evaluation is always followed by divider steps
    a_eval_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.eval |=> cmd.div_step)
        else $error("divider not started after evaluation");

    // No word taken while the store is swept
    a_no_accept_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_we |-> !s_tready)
        else $error("word accepted during clearing sweep");

endmodule
